// ----- sv/spwr_pkg.sv -----
// shared constants, register indexes and saturation helper for the speed pi block
`timescale 1ns / 1ps

package spwr_pkg;

   localparam int SPEED_W = 16;
   localparam int PHASE_W = 4;
   localparam int DRIVE_W = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // interpolation period in ticks
   localparam int RAMP_PERIOD = 16;

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MOVEMENT_BIAS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEG_GAIN = 2'd3;

   localparam logic signed [CSR_DATA_W-1:0] PROP_GAIN_RESET = 16'sd15;
   localparam logic signed [CSR_DATA_W-1:0] INTEG_GAIN_RESET = 16'sd1;

   // clamp a wide signed value into the 32-bit signed range
   function automatic logic signed [DRIVE_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v < lo) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[DRIVE_W-1:0];
      end
   endfunction

endpackage

// ----- sv/speed_pi_with_output_ramp.sv -----
// speed-loop pi controller with a ramped (interpolated) drive output
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  req     | req_valid req_stall req_type                 | in
//          | req_measured_speed req_phase                 |
//  rsp     | rsp_valid rsp_stall rsp_drive_value          | out
//  csr     | csr_wr_en csr_index csr_wr_data              | in
//
// one word is taken per cycle while the input register has room; a query word reaches
// the output register via the integral stage, then the output stage (gain multipliers).
// an update word gives no result and leaves the pipe after its second stage.
// synchronous reset clears valids, controller state, target and bias; gains go to 15 and 1.
// bubbles close up; while a result waits, words are still taken until a query is
// held in the second stage behind it and the input register is full.
`timescale 1ns / 1ps

module speed_pi_with_output_ramp
   import spwr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic signed [SPEED_W-1:0]    req_measured_speed,
   input  logic [PHASE_W-1:0]           req_phase,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DRIVE_W-1:0]    rsp_drive_value,
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wr_data
);

   localparam logic signed [38:0] RAMP_DIV = 39'(RAMP_PERIOD);

   // configuration
   logic signed [CSR_DATA_W-1:0] target_speed_ff;
   logic signed [CSR_DATA_W-1:0] movement_bias_ff;
   logic signed [CSR_DATA_W-1:0] prop_gain_ff;
   logic signed [CSR_DATA_W-1:0] integ_gain_ff;

   // controller state
   logic signed [DRIVE_W-1:0] integral_sum_ff, integral_sum_in;
   logic signed [DRIVE_W-1:0] previous_output_ff, previous_output_in;
   logic signed [DRIVE_W-1:0] latest_output_ff, latest_output_in;

   // input register
   logic                      p1_valid_ff, p1_valid_in;
   logic                      p1_type_ff;
   logic signed [SPEED_W-1:0] p1_meas_ff;
   logic [PHASE_W-1:0]        p1_phase_ff;

   // second stage
   logic                      p2_valid_ff, p2_valid_in;
   logic                      p2_type_ff;
   logic signed [SPEED_W:0]   p2_err_ff;
   logic [PHASE_W-1:0]        p2_phase_ff;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [DRIVE_W-1:0] rsp_drive_ff, rsp_drive_in;

   logic out_free, p2_go, p2_free, p1_go, p1_free, req_take;

   logic signed [SPEED_W:0]   err;
   logic signed [DRIVE_W-1:0] integ_a, integ_b;

   logic signed [32:0]        prop_term;
   logic signed [47:0]        integ_term;
   logic signed [48:0]        pi_sum;
   logic signed [DRIVE_W-1:0] new_latest;

   logic signed [32:0]        diff;
   logic signed [5:0]         ph_plus;
   logic signed [38:0]        ramp_prod;
   logic signed [38:0]        ramp_step;
   logic signed [39:0]        ramp_val;

   // handshake: bubbles collapse, an update needs no room at the output
   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      p2_go = p2_valid_ff && ((p2_type_ff == REQ_UPDATE) || out_free);
      p2_free = !p2_valid_ff || p2_go;
      p1_go = p1_valid_ff && p2_free;
      p1_free = !p1_valid_ff || p1_go;
      req_take = req_valid && p1_free;
   end

   assign req_stall = !p1_free;

   // integral stage
   always_comb begin
      err = 17'(target_speed_ff) - 17'(p1_meas_ff);
      integ_a = sat32(64'(integral_sum_ff) + 64'(err));
      integ_b = sat32(64'(integ_a) - 64'(movement_bias_ff));
   end

   // output stage: integral_sum_ff already holds this word's integral while it sits in p2
   always_comb begin
      prop_term = 33'(prop_gain_ff) * 33'(p2_err_ff);
      integ_term = 48'(integ_gain_ff) * 48'(integral_sum_ff);
      pi_sum = 49'(prop_term) + 49'(integ_term);
      new_latest = sat32(64'(pi_sum));

      diff = 33'(latest_output_ff) - 33'(previous_output_ff);
      ph_plus = $signed({2'b00, p2_phase_ff}) + 6'sd1;
      ramp_prod = 39'(diff) * 39'(ph_plus);
      // signed divide truncates toward zero
      ramp_step = ramp_prod / RAMP_DIV;
      ramp_val = 40'(previous_output_ff) + 40'(ramp_step);
   end

   always_comb begin
      p1_valid_in = req_take || (p1_valid_ff && !p1_go);
      p2_valid_in = p1_go || (p2_valid_ff && !p2_go);

      integral_sum_in = integral_sum_ff;
      if (p1_go && (p1_type_ff == REQ_UPDATE)) begin
         integral_sum_in = integ_b;
      end

      previous_output_in = previous_output_ff;
      latest_output_in = latest_output_ff;
      if (p2_go && (p2_type_ff == REQ_UPDATE)) begin
         previous_output_in = latest_output_ff;
         latest_output_in = new_latest;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_drive_in = rsp_drive_ff;
      if (p2_go && (p2_type_ff == REQ_QUERY)) begin
         rsp_valid_in = 1'b1;
         rsp_drive_in = sat32(64'(ramp_val));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_speed_ff <= '0;
         movement_bias_ff <= '0;
         prop_gain_ff <= PROP_GAIN_RESET;
         integ_gain_ff <= INTEG_GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_TARGET_SPEED: begin
               target_speed_ff <= $signed(csr_wr_data);
            end
            REG_MOVEMENT_BIAS: begin
               movement_bias_ff <= $signed(csr_wr_data);
            end
            REG_PROP_GAIN: begin
               prop_gain_ff <= $signed(csr_wr_data);
            end
            REG_INTEG_GAIN: begin
               integ_gain_ff <= $signed(csr_wr_data);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_sum_ff <= '0;
         previous_output_ff <= '0;
         latest_output_ff <= '0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         integral_sum_ff <= integral_sum_in;
         previous_output_ff <= previous_output_in;
         latest_output_ff <= latest_output_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         p1_type_ff <= req_type;
         p1_meas_ff <= req_measured_speed;
         p1_phase_ff <= req_phase;
      end
      if (p1_go) begin
         p2_type_ff <= p1_type_ff;
         p2_err_ff <= err;
         p2_phase_ff <= p1_phase_ff;
      end
      rsp_drive_ff <= rsp_drive_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive_value = rsp_drive_ff;

endmodule

// ----- sv/spwr_check.sv -----
// port-level checks for the speed pi block, bound to the top level
`timescale 1ns / 1ps

module spwr_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_type,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_drive_value
);

   // a stalled result word stays put
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_drive_value));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("result word changed or dropped while stalled");

   // nothing comes out straight after reset
   property p_reset_clears;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_reset_clears: assert property (p_reset_clears)
      else $error("result valid after reset");

   // with room at the output the whole pipe drains, so input is never stalled
   property p_no_false_stall;
      @(posedge clock) disable iff (reset)
         (!rsp_valid || !rsp_stall) |-> !req_stall;
   endproperty
   a_no_false_stall: assert property (p_no_false_stall)
      else $error("input stalled while output has room");

   // a query word taken with a free output shows up after the input and second stages
   property p_query_latency;
      @(posedge clock) disable iff (reset)
         (req_valid && !req_stall && req_type) ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid;
   endproperty
   a_query_latency: assert property (p_query_latency)
      else $error("query result missing after pipeline latency");

endmodule

bind speed_pi_with_output_ramp spwr_check u_spwr_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive_value (rsp_drive_value)
);
